FILE: rtl/ffbc_pkg.sv
package ffbc_pkg;

  localparam int SIZE_W       = 40;
  localparam int IN_HANDLE_W  = 16;
  localparam int OUT_HANDLE_W = 16;
  localparam int HELD_W       = 5;
  localparam int ACTION_W     = 2;

  // Request kinds.
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result actions.
  localparam logic [ACTION_W-1:0] ACT_SERVED     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC_FWD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REL_CACHED = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_REL_FWD    = 2'd3;

  typedef struct packed {
    logic                   req_type;
    logic                   device_local;
    logic [SIZE_W-1:0]      buffer_size;
    logic [IN_HANDLE_W-1:0] buffer_handle;
  } ffbc_req_t;

  typedef struct packed {
    logic [ACTION_W-1:0]     action;
    logic [OUT_HANDLE_W-1:0] out_handle;
    logic [HELD_W-1:0]       entries_held;
  } ffbc_rsp_t;

endpackage

FILE: rtl/ffbc_if.sv
interface ffbc_req_if;
  import ffbc_pkg::*;

  logic      valid;
  logic      ready;
  ffbc_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ffbc_rsp_if;
  import ffbc_pkg::*;

  logic      valid;
  logic      ready;
  ffbc_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/ffbc_entry_ram.sv
module ffbc_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 56,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the controller never reads and writes one entry in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/first_fit_buffer_cache_core.sv
// First-fit cache of freed device-local buffers.
//
// Requests arrive on the req channel (valid/ready): an allocate asks for a
// buffer of at least buffer_size bytes, a release hands back a buffer with its
// size and handle. Every request yields exactly one response on the rsp channel
// with the action taken, the handle given out on a hit, and the entry count.
//
// The list lives in one entry memory with a registered read port and a write
// port, and one request is worked on at a time. An allocate scans from the
// front one entry per cycle and, on a hit, moves the later entries up one
// place; a release smaller than the head moves every entry down one place
// first. These passes set how long a request takes. A release not smaller
// than the head is written at the tail. Once the response is loaded into
// the output register, the controller goes idle and the next request is
// taken in the cycle after that load.
//
// Reset clears the entry count, the controller and the response valid flag, not
// the memory. A stalled receiver holds the response in place; the next request
// is taken while it waits, and its own response waits until the register frees.
module first_fit_buffer_cache_core #(
  parameter int CACHE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  ffbc_req_if.sink   req,
  ffbc_rsp_if.source rsp
);
  import ffbc_pkg::*;

  localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
  localparam int ENT_W = SIZE_W + HANDLE_BITS;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CACHE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_CNT   = CNT_W'(2);

  // Controller states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEARCH   = 3'd1;
  localparam logic [2:0] ST_SHIFT_UP = 3'd2;
  localparam logic [2:0] ST_HEAD     = 3'd3;
  localparam logic [2:0] ST_SHIFT_DN = 3'd4;
  localparam logic [2:0] ST_INS0     = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  logic [2:0] state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;

  // The request being worked on.
  logic [SIZE_W-1:0]      cur_size, cur_size_next;
  logic [HANDLE_BITS-1:0] cur_handle, cur_handle_next;

  // Response waiting to be loaded into the output register.
  logic [ACTION_W-1:0]     res_action, res_action_next;
  logic [OUT_HANDLE_W-1:0] res_handle, res_handle_next;
  logic [CNT_W-1:0]        res_count, res_count_next;

  logic      out_valid, out_valid_next;
  ffbc_rsp_t out_pld, out_pld_next;

  // Entry memory ports.
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0] rd_data, wr_data;

  logic [SIZE_W-1:0]      rd_size;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [31:0]            rd_handle_ext;
  logic [31:0]            in_handle_ext;
  logic [HANDLE_BITS-1:0] in_handle;
  logic [31:0]            held_ext;
  logic [CNT_W-1:0]       idx_p1, idx_p2, idx_m1, count_m1, count_p1;

  assign rd_size       = rd_data[ENT_W-1 -: SIZE_W];
  assign rd_handle     = rd_data[HANDLE_BITS-1:0];
  assign rd_handle_ext = 32'(rd_handle);
  assign in_handle_ext = 32'(req.payload.buffer_handle);
  assign in_handle     = in_handle_ext[HANDLE_BITS-1:0];
  assign held_ext      = 32'(res_count);

  assign idx_p1   = idx + ONE_CNT;
  assign idx_p2   = idx + TWO_CNT;
  assign idx_m1   = idx - ONE_CNT;
  assign count_m1 = count - ONE_CNT;
  assign count_p1 = count + ONE_CNT;

  ffbc_entry_ram #(
    .DEPTH (CACHE_DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // A new request is taken whenever the controller is idle, even with a
  // response still waiting in the output register.
  assign req.ready   = (state == ST_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_pld;

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    cur_size_next   = cur_size;
    cur_handle_next = cur_handle;
    res_action_next = res_action;
    res_handle_next = res_handle;
    res_count_next  = res_count;
    out_valid_next  = out_valid && !rsp.ready;
    out_pld_next    = out_pld;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = {cur_size, cur_handle};

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          cur_size_next   = req.payload.buffer_size;
          cur_handle_next = in_handle;
          res_handle_next = '0;
          res_count_next  = count;
          if (req.payload.req_type == REQ_ALLOC) begin
            if (req.payload.device_local && count != '0) begin
              // Start the scan at the head.
              rd_en      = 1'b1;
              rd_addr    = '0;
              idx_next   = '0;
              state_next = ST_SEARCH;
            end else begin
              res_action_next = ACT_ALLOC_FWD;
              state_next      = ST_DONE;
            end
          end else begin
            if (req.payload.device_local && count < DEPTH_CNT) begin
              res_action_next = ACT_REL_CACHED;
              res_count_next  = count_p1;
              if (count != '0) begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_HEAD;
              end else begin
                // Empty list: the buffer becomes the only entry.
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = {req.payload.buffer_size, in_handle};
                state_next = ST_DONE;
              end
            end else begin
              res_action_next = ACT_REL_FWD;
              state_next      = ST_DONE;
            end
          end
        end
      end

      ST_SEARCH: begin
        if (rd_size >= cur_size) begin
          res_action_next = ACT_SERVED;
          res_handle_next = rd_handle_ext[OUT_HANDLE_W-1:0];
          res_count_next  = count_m1;
          if (idx_p1 < count) begin
            // Close the gap left by the hit; idx is the slot to fill.
            rd_en      = 1'b1;
            rd_addr    = idx_p1[IDX_W-1:0];
            state_next = ST_SHIFT_UP;
          end else begin
            state_next = ST_DONE;
          end
        end else if (idx_p1 < count) begin
          rd_en    = 1'b1;
          rd_addr  = idx_p1[IDX_W-1:0];
          idx_next = idx_p1;
        end else begin
          res_action_next = ACT_ALLOC_FWD;
          state_next      = ST_DONE;
        end
      end

      ST_SHIFT_UP: begin
        wr_en    = 1'b1;
        wr_addr  = idx[IDX_W-1:0];
        wr_data  = rd_data;
        idx_next = idx_p1;
        if (idx_p2 < count) begin
          rd_en   = 1'b1;
          rd_addr = idx_p2[IDX_W-1:0];
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_HEAD: begin
        if (rd_size > cur_size) begin
          // Smaller than the head: move everything down, last entry first.
          rd_en      = 1'b1;
          rd_addr    = count_m1[IDX_W-1:0];
          idx_next   = count;
          state_next = ST_SHIFT_DN;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = count[IDX_W-1:0];
          state_next = ST_DONE;
        end
      end

      ST_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = idx[IDX_W-1:0];
        wr_data = rd_data;
        if (idx == ONE_CNT) begin
          state_next = ST_INS0;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx_p2[IDX_W-1:0] - IDX_W'(4);
          idx_next = idx_m1;
        end
      end

      ST_INS0: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next            = 1'b1;
          out_pld_next.action       = res_action;
          out_pld_next.out_handle   = res_handle;
          out_pld_next.entries_held = held_ext[HELD_W-1:0];
          count_next                = res_count;
          state_next                = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    cur_size   <= cur_size_next;
    cur_handle <= cur_handle_next;
    res_action <= res_action_next;
    res_handle <= res_handle_next;
    res_count  <= res_count_next;
    out_pld    <= out_pld_next;
  end

endmodule

FILE: rtl/ffbc_checker.sv
module ffbc_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input ffbc_pkg::ffbc_rsp_t rsp_payload
);
  import ffbc_pkg::*;

  // A stalled response stays offered.
  a_rsp_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // A stalled response keeps its contents.
  a_rsp_hold_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_payload))
    else $error("response changed while stalled");

  // One request at a time: taking a request closes the input for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  // A handle is only given out on a hit.
  a_handle_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload.action != ACT_SERVED |-> rsp_payload.out_handle == '0)
    else $error("handle given out without a hit");

endmodule

bind first_fit_buffer_cache_core ffbc_checker u_ffbc_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);
